// File: design/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the 12-bit hashed-table LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int TABLE_ENTRIES   = 4096;
   localparam int IDX_W           = 12;
   localparam int STRING_MAX_DEF  = 512;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [15:0] ROOT_KEY   = 16'hFFFF;
   localparam logic [15:0] SQ_OR      = 16'h0800;
   localparam logic [15:0] MUL_K      = 16'd15073;
   localparam logic [11:0] PROBE_STEP = 12'd101;
   localparam logic [11:0] ROOT_PRED  = 12'hFFF;
   localparam logic [11:0] MAX_ADDS   = 12'd3840;
   localparam logic [11:0] IDX_LAST   = 12'hFFF;
   localparam logic [7:0]  SEED_LAST  = 8'hFF;

   typedef struct packed {
      logic        is_start;
      logic [11:0] code;
   } lzwd_cmd_type;

   typedef struct packed {
      logic        used;
      logic        root;
      logic [11:0] nxt;
      logic [11:0] pred;
      logic [7:0]  foll;
   } lzwd_entry_type;

   typedef enum logic [1:0] {
      NIB_EMPTY,
      NIB_BYTE,
      NIB_HALF
   } lzwd_nib_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SEED,
      ST_IDLE,
      ST_CODE,
      ST_WALK,
      ST_INS_HASH,
      ST_INS_RD,
      ST_INS_CHAIN,
      ST_INS_PROBE,
      ST_INS_NEW,
      ST_ROOT,
      ST_STACK,
      ST_TAIL,
      ST_FLUSH,
      ST_LAST,
      ST_OVF
   } lzwd_state_type;

endpackage

// File: design/lzwd_front.sv
// ----------------------------------------------------------------------------
// lzwd_front
// Byte intake: cuts the byte stream into 12-bit codes and queues codes and
// stream-start commands for the back end.
// ----------------------------------------------------------------------------
module lzwd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_start_stream,
   output logic                  q_push,
   output lzwd_pkg::lzwd_cmd_type q_data,
   input  logic                  q_full
);
   import lzwd_pkg::*;

   lzwd_nib_type nib_ff, nib_in;
   logic [7:0]   val_ff, val_in;
   logic         accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_ff <= NIB_EMPTY;
      end else begin
         nib_ff <= nib_in;
      end
      val_ff <= val_in;
   end

   always_comb begin
      nib_in      = nib_ff;
      val_in      = val_ff;
      q_push      = 1'b0;
      q_data      = '0;
      if (accept) begin
         if (req_start_stream) begin
            q_push          = 1'b1;
            q_data.is_start = 1'b1;
            val_in          = req_in_byte;
            nib_in          = NIB_BYTE;
         end else begin
            case (nib_ff)
               NIB_EMPTY: begin
                  val_in = req_in_byte;
                  nib_in = NIB_BYTE;
               end
               NIB_BYTE: begin
                  q_push      = 1'b1;
                  q_data.code = {val_ff, req_in_byte[7:4]};
                  val_in      = {4'b0, req_in_byte[3:0]};
                  nib_in      = NIB_HALF;
               end
               NIB_HALF: begin
                  q_push      = 1'b1;
                  q_data.code = {val_ff[3:0], req_in_byte};
                  nib_in      = NIB_EMPTY;
               end
               default: begin
                  nib_in = NIB_EMPTY;
               end
            endcase
         end
      end
   end

endmodule

// File: design/lzwd_fifo.sv
// ----------------------------------------------------------------------------
// lzwd_fifo
// Short command queue between the byte intake and the table engine.
// ----------------------------------------------------------------------------
module lzwd_fifo #(
   parameter int DEPTH = lzwd_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lzwd_pkg::lzwd_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output lzwd_pkg::lzwd_cmd_type pop_data,
   output logic                   empty
);
   import lzwd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

   lzwd_cmd_type  slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_FULL);
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: design/lzwd_back.sv
// ----------------------------------------------------------------------------
// lzwd_back
// Table engine: string table clear and seed, string walk, hashed insert
// with chain walk and linear probe, and packing of decoded bytes into beats.
// ----------------------------------------------------------------------------
module lzwd_back #(
   parameter int STRING_MAX = lzwd_pkg::STRING_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_hash_select,
   input  logic                   q_empty,
   input  lzwd_pkg::lzwd_cmd_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [63:0]            rsp_out_bytes,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_last,
   output logic                   rsp_overflow
);
   import lzwd_pkg::*;

   localparam int SP_W = $clog2(STRING_MAX + 1);
   localparam int SA_W = $clog2(STRING_MAX);
   localparam logic [SP_W-1:0] SP_MAX = SP_W'(STRING_MAX);

   // memories
   lzwd_entry_type tbl_mem [TABLE_ENTRIES];
   lzwd_entry_type tbl_rd_ff, tbl_wd;
   logic           tbl_we, tbl_re;
   logic [11:0]    tbl_wa, tbl_ra;

   logic [7:0]     stk_mem [STRING_MAX];
   logic [7:0]     stk_rd_ff, stk_wd;
   logic           stk_we, stk_re;
   logic [SA_W-1:0] stk_wa, stk_ra;

   // control state
   lzwd_state_type state_ff, state_in, ret_ff, ret_in;
   logic        hash_ff, hash_in;
   logic        seed_zero_ff, seed_zero_in;
   logic        halted_ff, halted_in;
   logic        first_ff, first_in;
   logic [11:0] clr_ff, clr_in;
   logic [7:0]  seed_ff, seed_in;
   logic [11:0] left_ff, left_in;
   logic [11:0] prev_ff, prev_in;
   logic [7:0]  final_ff, final_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [11:0] code_ff, code_in;
   logic        unk_ff, unk_in;
   logic [7:0]  lastc_ff, lastc_in;
   logic [7:0]  rootb_ff, rootb_in;
   logic        ins_root_ff, ins_root_in;
   logic        ins_seed_ff, ins_seed_in;
   logic        ins_sel_ff, ins_sel_in;
   logic [11:0] ins_pred_ff, ins_pred_in;
   logic [7:0]  ins_foll_ff, ins_foll_in;
   logic [31:0] prod_ff, prod_in;
   logic [11:0] at_ff, at_in;
   logic [11:0] probe_ff, probe_in;
   lzwd_entry_type link_ff, link_in;
   logic [63:0] buf_ff, buf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   // helpers
   logic [15:0] ins_sum, mul_a, mul_b;
   logic [11:0] hash_at;
   logic        out_free;
   logic [SP_W-1:0] sp_m1;
   logic [SP_W:0]   sp_need;
   lzwd_entry_type  new_entry, e;
   logic [63:0] app_stack, app_last;

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bytes  = rsp_bytes_ff;
   assign rsp_byte_count = rsp_cnt_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign e        = tbl_rd_ff;
   assign sp_m1    = sp_ff - 1'b1;
   assign sp_need  = {1'b0, sp_ff} + {{SP_W{1'b0}}, unk_ff};

   assign ins_sum = ins_root_ff ? (ROOT_KEY + {8'b0, ins_foll_ff})
                                : ({4'b0, ins_pred_ff} + {8'b0, ins_foll_ff});
   assign mul_a   = ins_sel_in ? ins_sum : (ins_sum | SQ_OR);
   assign mul_b   = ins_sel_in ? MUL_K : (ins_sum | SQ_OR);
   assign hash_at = ins_sel_ff ? prod_ff[11:0] : prod_ff[17:6];

   assign app_stack = buf_ff | ({56'b0, stk_rd_ff} << {cnt_ff[2:0], 3'b000});
   assign app_last  = buf_ff | ({56'b0, lastc_ff} << {cnt_ff[2:0], 3'b000});

   always_comb begin
      new_entry      = '0;
      new_entry.used = 1'b1;
      new_entry.root = ins_root_ff;
      new_entry.pred = ins_pred_ff;
      new_entry.foll = ins_foll_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      hash_in      = hash_ff;
      seed_zero_in = seed_zero_ff;
      halted_in    = halted_ff;
      first_in     = first_ff;
      clr_in       = clr_ff;
      seed_in      = seed_ff;
      left_in      = left_ff;
      prev_in      = prev_ff;
      final_in     = final_ff;
      sp_in        = sp_ff;
      code_in      = code_ff;
      unk_in       = unk_ff;
      lastc_in     = lastc_ff;
      rootb_in     = rootb_ff;
      ins_root_in  = ins_root_ff;
      ins_seed_in  = ins_seed_ff;
      ins_sel_in   = ins_sel_ff;
      ins_pred_in  = ins_pred_ff;
      ins_foll_in  = ins_foll_ff;
      prod_in      = prod_ff;
      at_in        = at_ff;
      probe_in     = probe_ff;
      link_in      = link_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      tbl_we       = 1'b0;
      tbl_wa       = clr_ff;
      tbl_wd       = '0;
      tbl_re       = 1'b0;
      tbl_ra       = code_ff;
      stk_we       = 1'b0;
      stk_wa       = sp_ff[SA_W-1:0];
      stk_wd       = e.foll;
      stk_re       = 1'b0;
      stk_ra       = sp_m1[SA_W-1:0];

      if (csr_valid) begin
         hash_in = csr_hash_select;
      end

      case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_LAST) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            ins_root_in = 1'b1;
            ins_seed_in = 1'b1;
            ins_pred_in = ROOT_PRED;
            ins_foll_in = seed_ff;
            state_in    = ST_INS_HASH;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (!halted_ff) begin
                  if (q_data.is_start) begin
                     clr_in   = '0;
                     prev_in  = '0;
                     final_in = '0;
                     left_in  = MAX_ADDS;
                     first_in = 1'b1;
                     state_in = ST_CLEAR;
                  end else begin
                     code_in  = q_data.code;
                     tbl_re   = 1'b1;
                     tbl_ra   = q_data.code;
                     state_in = ST_CODE;
                  end
               end
            end
         end
         ST_CODE: begin
            if (first_ff) begin
               buf_in   = {56'b0, e.foll};
               cnt_in   = 4'd1;
               final_in = e.foll;
               prev_in  = code_ff;
               first_in = 1'b0;
               state_in = ST_LAST;
            end else begin
               unk_in   = !e.used;
               lastc_in = final_ff;
               tbl_re   = 1'b1;
               tbl_ra   = e.used ? code_ff : prev_ff;
               sp_in    = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!e.root && (sp_ff < SP_MAX)) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + 1'b1;
               tbl_re = 1'b1;
               tbl_ra = e.pred;
            end else if (sp_need >= {1'b0, SP_MAX}) begin
               state_in = ST_OVF;
            end else begin
               rootb_in = e.foll;
               final_in = unk_ff ? lastc_ff : e.foll;
               prev_in  = code_ff;
               if (left_ff != '0) begin
                  left_in     = left_ff - 1'b1;
                  ins_root_in = 1'b0;
                  ins_seed_in = 1'b0;
                  ins_pred_in = prev_ff;
                  ins_foll_in = unk_ff ? lastc_ff : e.foll;
                  state_in    = ST_INS_HASH;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_INS_HASH: begin
            ins_sel_in = seed_zero_ff ? 1'b0 : hash_ff;
            prod_in    = mul_a * mul_b;
            state_in   = ST_INS_RD;
         end
         ST_INS_RD: begin
            at_in    = hash_at;
            tbl_re   = 1'b1;
            tbl_ra   = hash_at;
            state_in = ST_INS_CHAIN;
         end
         ST_INS_CHAIN: begin
            if (!e.used) begin
               tbl_we   = 1'b1;
               tbl_wa   = at_ff;
               tbl_wd   = new_entry;
               state_in = ST_INS_NEW;
               ret_in   = ST_INS_CHAIN;
            end else if (e.nxt != '0) begin
               at_in  = e.nxt;
               tbl_re = 1'b1;
               tbl_ra = e.nxt;
            end else begin
               link_in  = e;
               probe_in = at_ff + PROBE_STEP;
               tbl_re   = 1'b1;
               tbl_ra   = at_ff + PROBE_STEP;
               state_in = ST_INS_PROBE;
            end
            if (!e.used) begin
               // insert finished in place
               if (ins_seed_ff) begin
                  seed_in = seed_ff + 1'b1;
                  if (seed_ff == SEED_LAST) begin
                     seed_zero_in = 1'b0;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_SEED;
                  end
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_INS_PROBE: begin
            if (e.used) begin
               probe_in = probe_ff + 1'b1;
               tbl_re   = 1'b1;
               tbl_ra   = probe_ff + 1'b1;
            end else begin
               tbl_we     = 1'b1;
               tbl_wa     = at_ff;
               tbl_wd     = link_ff;
               tbl_wd.nxt = probe_ff;
               state_in   = ST_INS_NEW;
            end
         end
         ST_INS_NEW: begin
            tbl_we = 1'b1;
            tbl_wa = probe_ff;
            tbl_wd = new_entry;
            if (ins_seed_ff) begin
               seed_in = seed_ff + 1'b1;
               if (seed_ff == SEED_LAST) begin
                  seed_zero_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_SEED;
               end
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            buf_in = {56'b0, rootb_ff};
            cnt_in = 4'd1;
            if (sp_ff != '0) begin
               stk_re   = 1'b1;
               sp_in    = sp_m1;
               state_in = ST_STACK;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_STACK: begin
            if (cnt_ff == 4'd8) begin
               ret_in   = ST_STACK;
               state_in = ST_FLUSH;
            end else begin
               buf_in = app_stack;
               cnt_in = cnt_ff + 1'b1;
               if (sp_ff != '0) begin
                  stk_re = 1'b1;
                  sp_in  = sp_m1;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (!unk_ff) begin
               state_in = ST_LAST;
            end else if (cnt_ff == 4'd8) begin
               ret_in   = ST_TAIL;
               state_in = ST_FLUSH;
            end else begin
               buf_in   = app_last;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_LAST;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bytes_in = buf_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = 1'b0;
               buf_in       = '0;
               cnt_in       = '0;
               state_in     = ret_ff;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bytes_in = buf_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_OVF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bytes_in = '0;
               rsp_cnt_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = 1'b1;
               halted_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         hash_ff      <= 1'b0;
         seed_zero_ff <= 1'b1;
         halted_ff    <= 1'b0;
         first_ff     <= 1'b1;
         clr_ff       <= '0;
         seed_ff      <= '0;
         left_ff      <= MAX_ADDS;
         prev_ff      <= '0;
         final_ff     <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         hash_ff      <= hash_in;
         seed_zero_ff <= seed_zero_in;
         halted_ff    <= halted_in;
         first_ff     <= first_in;
         clr_ff       <= clr_in;
         seed_ff      <= seed_in;
         left_ff      <= left_in;
         prev_ff      <= prev_in;
         final_ff     <= final_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff      <= code_in;
      unk_ff       <= unk_in;
      lastc_ff     <= lastc_in;
      rootb_ff     <= rootb_in;
      ins_root_ff  <= ins_root_in;
      ins_seed_ff  <= ins_seed_in;
      ins_sel_ff   <= ins_sel_in;
      ins_pred_ff  <= ins_pred_in;
      ins_foll_ff  <= ins_foll_in;
      prod_ff      <= prod_in;
      at_ff        <= at_in;
      probe_ff     <= probe_in;
      link_ff      <= link_in;
      buf_ff       <= buf_in;
      cnt_ff       <= cnt_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_ra];
      end
   end

   a_ovf_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_cnt_ff == 4'd0 && rsp_last_ff)
      else $error("overflow beat carries data");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ovf_ff |-> rsp_cnt_ff != 4'd0 && rsp_cnt_ff <= 4'd8)
      else $error("data beat byte count out of range");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_MAX)
      else $error("stack pointer beyond string limit");

endmodule

// File: design/lzw12_hashed_table_decoder_top.sv
// ----------------------------------------------------------------------------
// lzw12_hashed_table_decoder_top
// 12-bit LZW decoder with a hashed 4096-entry string table.
// ----------------------------------------------------------------------------
// path from the byte completing a code to its last beat: queue, table read,
//   string walk, insert while adds remain (hash, read, chain, probe), root,
//   stack, tail, a flush per full beat; a stream's first code is a single beat
// throughput: one code at a time, popped only in the idle state
// reset and stream start: clearing pass over all 4096 entries, then 256 seed
//   inserts; no byte is decoded until both finish
module lzw12_hashed_table_decoder_top #(
   parameter int STRING_MAX = lzwd_pkg::STRING_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_hash_select
);
   import lzwd_pkg::*;

   lzwd_cmd_type push_data, pop_data;
   logic         push, full, pop, empty;

   lzwd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_start_stream (req_start_stream),
      .q_push           (push),
      .q_data           (push_data),
      .q_full           (full)
   );

   lzwd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   lzwd_back #(.STRING_MAX(STRING_MAX)) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hash_select (csr_hash_select),
      .q_empty         (empty),
      .q_data          (pop_data),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_bytes   (rsp_out_bytes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
